// ===== hw/rtl/rpcr_pkg.sv =====
// Package for the RF pulse code receiver: mode codes, register indexes,
// the classified pulse record and the field widths. No dependencies.
package rpcr_pkg;

    localparam int PulseW = 24;
    localparam int WordW  = 32;
    localparam int CountW = 8;
    localparam int BitsW  = 6;
    localparam int CfgIdxW = 3;

    localparam logic [PulseW-1:0] NoiseFloorReset = 24'd100;

    localparam logic [BitsW-1:0] BitsPw28   = 6'd28;
    localparam logic [BitsW-1:0] BitsClkGap = 6'd32;
    localparam logic [BitsW-1:0] BitsMulti  = 6'd32;
    localparam logic [BitsW-1:0] BitsPw24   = 6'd24;

    typedef enum logic [1:0] {
        MODE_PW28   = 2'd0,
        MODE_CLKGAP = 2'd1,
        MODE_MULTI  = 2'd2,
        MODE_PW24   = 2'd3
    } mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MODE          = 3'd0,
        REG_SYNC_MIN      = 3'd1,
        REG_SYNC_MAX      = 3'd2,
        REG_BIT_THRESHOLD = 3'd3,
        REG_NOISE_FLOOR   = 3'd4
    } reg_index_t;

    // One edge after classification against the configured limits.
    typedef struct packed {
        logic level;
        logic gt_thr;       // pulse longer than bit_threshold
        logic ge_thr;       // pulse not shorter than bit_threshold
        logic below_noise;  // pulse shorter than noise_floor
        logic in_sync;      // sync_min < pulse < sync_max
    } pulse_class_t;

endpackage

// ===== hw/rtl/rpcr_front.sv =====
// Front end of the RF pulse code receiver: configuration registers and the
// classification of each incoming edge. Depends on rpcr_pkg.
module rpcr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rpcr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rpcr_pkg::PulseW-1:0]  cfg_data,
    input  logic                         level,
    input  logic [rpcr_pkg::PulseW-1:0]  pulse_us,
    output rpcr_pkg::pulse_class_t       pulse_class,
    output rpcr_pkg::mode_t              mode
);
    import rpcr_pkg::*;

    mode_t              mode_reg;
    logic [PulseW-1:0]  sync_min_reg;
    logic [PulseW-1:0]  sync_max_reg;
    logic [PulseW-1:0]  bit_threshold_reg;
    logic [PulseW-1:0]  noise_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_PW28;
            sync_min_reg      <= '0;
            sync_max_reg      <= '0;
            bit_threshold_reg <= '0;
            noise_floor_reg   <= NoiseFloorReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:          mode_reg          <= mode_t'(cfg_data[1:0]);
                REG_SYNC_MIN:      sync_min_reg      <= cfg_data;
                REG_SYNC_MAX:      sync_max_reg      <= cfg_data;
                REG_BIT_THRESHOLD: bit_threshold_reg <= cfg_data;
                REG_NOISE_FLOOR:   noise_floor_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        pulse_class.level       = level;
        pulse_class.gt_thr      = pulse_us > bit_threshold_reg;
        pulse_class.ge_thr      = pulse_us >= bit_threshold_reg;
        pulse_class.below_noise = pulse_us < noise_floor_reg;
        pulse_class.in_sync     = (pulse_us > sync_min_reg) && (pulse_us < sync_max_reg);
    end

    assign mode = mode_reg;

endmodule

// ===== hw/rtl/rpcr_queue.sv =====
// Short queue of classified edges between the front and back ends of the
// RF pulse code receiver. Depends on rpcr_pkg.
module rpcr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rpcr_pkg::pulse_class_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output rpcr_pkg::pulse_class_t pop_data
);
    import rpcr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    pulse_class_t   entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/rpcr_back.sv =====
// Back end of the RF pulse code receiver: frame state, bit decoding per
// mode and the registered result stage. Depends on rpcr_pkg.
module rpcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpcr_pkg::mode_t        mode,
    input  logic                   q_valid,
    input  rpcr_pkg::pulse_class_t q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,  // code_word, transmitter_id, command,
                                             // channel, group_count
    output logic                   m_tuser,  // kind
    output logic                   m_tlast
);
    import rpcr_pkg::*;

    logic [WordW-1:0]  shift_reg, shift_next;
    logic [BitsW-1:0]  bits_left_reg, bits_left_next;
    logic              expect_clock_reg, expect_clock_next;
    logic [CountW-1:0] short_count_reg, short_count_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    logic              emit;
    logic              res_kind;
    logic [WordW-1:0]  res_word;
    logic              res_split;
    logic [CountW-1:0] res_count;
    logic              res_last;
    logic [BitsW-1:0]  bits_dec;
    logic              in_frame;
    logic              pw_mode;

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign in_frame = (bits_left_reg != '0);
    assign pw_mode  = (mode == MODE_PW28) || (mode == MODE_PW24);
    assign bits_dec = bits_left_reg - 1'b1;

    always_comb
    begin
        shift_next        = shift_reg;
        bits_left_next    = bits_left_reg;
        expect_clock_next = expect_clock_reg;
        short_count_next  = short_count_reg;
        emit      = 1'b0;
        res_kind  = 1'b0;
        res_word  = '0;
        res_split = 1'b0;
        res_count = '0;
        res_last  = 1'b0;

        if (in_frame && pw_mode && !q_data.level)
        begin
            shift_next     = {shift_reg[WordW-2:0], q_data.gt_thr};
            bits_left_next = bits_dec;
            emit           = (bits_dec == '0);
            res_word       = shift_next;
            res_last       = 1'b1;
        end
        else if (in_frame && (mode == MODE_CLKGAP) && q_data.level)
        begin
            if (expect_clock_reg)
            begin
                expect_clock_next = 1'b0;
                shift_next        = {shift_reg[WordW-2:0], 1'b0};
            end
            else
            begin
                shift_next        = {shift_reg[WordW-1:1], shift_reg[0] | q_data.ge_thr};
                expect_clock_next = 1'b1;
                bits_left_next    = bits_dec;
                emit              = (bits_dec == '0);
                res_word          = shift_next;
                res_split         = 1'b1;
                res_last          = 1'b1;
            end
        end
        else if (in_frame && (mode == MODE_MULTI) && q_data.level)
        begin
            if (!q_data.ge_thr)
            begin
                short_count_next = short_count_reg + 1'b1;
            end
            else
            begin
                bits_left_next   = bits_dec;
                emit             = 1'b1;
                res_kind         = 1'b1;
                res_count        = short_count_reg;
                res_last         = (bits_dec == '0);
                short_count_next = '0;
            end
        end
        else if (!q_data.below_noise && q_data.level && q_data.in_sync)
        begin
            // A sync pulse at level high opens or restarts a frame; the short count survives.
            shift_next = '0;
            unique case (mode)
                MODE_PW28:   bits_left_next = BitsPw28;
                MODE_CLKGAP:
                begin
                    bits_left_next    = BitsClkGap;
                    expect_clock_next = 1'b0;
                end
                MODE_MULTI:  bits_left_next = BitsMulti;
                MODE_PW24:   bits_left_next = BitsPw24;
                default:     bits_left_next = BitsPw24;
            endcase
        end

        if (!q_pop)
        begin
            shift_next        = shift_reg;
            bits_left_next    = bits_left_reg;
            expect_clock_next = expect_clock_reg;
            short_count_next  = short_count_reg;
            emit              = 1'b0;
        end

        if (q_pop)
        begin
            m_tvalid_next = emit;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg        <= '0;
            bits_left_reg    <= '0;
            expect_clock_reg <= 1'b0;
            short_count_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            shift_reg        <= shift_next;
            bits_left_reg    <= bits_left_next;
            expect_clock_reg <= expect_clock_next;
            short_count_reg  <= short_count_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg[31:0]  <= res_word;
            m_tdata_reg[47:32] <= res_split ? res_word[23:8] : 16'd0;
            m_tdata_reg[51:48] <= res_split ? res_word[7:4] : 4'd0;
            m_tdata_reg[55:52] <= res_split ? res_word[3:0] : 4'd0;
            m_tdata_reg[63:56] <= res_count;
            m_tuser_reg        <= res_kind;
            m_tlast_reg        <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hw/rtl/rf_pulse_code_receiver_core.sv =====
// RF pulse code receiver: decodes remote-control code words from receiver edges.
// Timing: an accepted edge is queued; the back end pops it while the output register
// is free or being taken, and a result enters that register as its edge is popped.
// Throughput: one edge per cycle into the frame state unless the output side stalls.
// Reset: frame state cleared, control registers zero except noise_floor, which is 100.
// Depends on rpcr_pkg, rpcr_front, rpcr_queue and rpcr_back.
module rf_pulse_code_receiver_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rpcr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rpcr_pkg::PulseW-1:0]  cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // pulse_us
    input  logic                         s_tuser,  // level
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata,  // code_word, transmitter_id, command,
                                                   // channel, group_count
    output logic                         m_tuser,  // kind
    output logic                         m_tlast
);
    import rpcr_pkg::*;

    pulse_class_t in_class;
    pulse_class_t q_data;
    mode_t        mode;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    logic         push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    rpcr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .level       (s_tuser),
        .pulse_us    (s_tdata),
        .pulse_class (in_class),
        .mode        (mode)
    );

    rpcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_class),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    rpcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/rpcr_code_checker.sv =====
// Scoreboard for the RF pulse code receiver: follows the register writes and both
// streams, predicts each decoded result and compares it with what the core sends.
// Depends on rpcr_pkg.
module rpcr_code_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rpcr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rpcr_pkg::PulseW-1:0]  cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // pulse_us
    input  logic                         s_tuser,   // level
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [63:0]                  m_tdata,   // code_word, transmitter_id, command,
                                                    // channel, group_count
    input  logic                         m_tuser,   // kind
    input  logic                         m_tlast,
    output int                           fail_count,
    output int                           codes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rpcr_pkg::*;

    typedef struct {
        logic              kind;
        logic [WordW-1:0]  code_word;
        logic [15:0]       transmitter_id;
        logic [3:0]        command;
        logic [3:0]        channel;
        logic [CountW-1:0] group_count;
        logic              last;
    } code_result_t;

    code_result_t      expected_codes[$];
    code_result_t      want;

    mode_t             mode_q;
    logic [PulseW-1:0] sync_min_q;
    logic [PulseW-1:0] sync_max_q;
    logic [PulseW-1:0] threshold_q;
    logic [PulseW-1:0] noise_floor_q;

    logic [WordW-1:0]  shift_code;
    logic [BitsW-1:0]  bits_left;
    logic              expect_clock;
    logic [CountW-1:0] short_count;

    function automatic code_result_t make_result(input logic kind, input logic [WordW-1:0] word,
                                                 input logic split, input logic [CountW-1:0] count,
                                                 input logic last);
        code_result_t r;
        r.kind           = kind;
        r.code_word      = word;
        r.transmitter_id = split ? word[23:8] : '0;
        r.command        = split ? word[7:4] : '0;
        r.channel        = split ? word[3:0] : '0;
        r.group_count    = count;
        r.last           = last;
        return r;
    endfunction

    // Applies one edge to the predicted frame state and queues any result it produces.
    function automatic void decode_edge(input logic lvl, input logic [PulseW-1:0] pulse);
        logic pw_mode;
        pw_mode = (mode_q == MODE_PW28) || (mode_q == MODE_PW24);
        if (bits_left != '0) begin
            if (pw_mode && !lvl) begin
                shift_code = {shift_code[WordW-2:0], pulse > threshold_q};
                bits_left  = bits_left - 1'b1;
                if (bits_left == '0)
                    expected_codes.push_back(make_result(1'b0, shift_code, 1'b0, '0, 1'b1));
                return;
            end
            if (mode_q == MODE_CLKGAP && lvl) begin
                if (expect_clock) begin
                    expect_clock = 1'b0;
                    shift_code   = shift_code << 1;
                    return;
                end
                shift_code[0] = shift_code[0] | (pulse >= threshold_q);
                expect_clock  = 1'b1;
                bits_left     = bits_left - 1'b1;
                if (bits_left == '0)
                    expected_codes.push_back(make_result(1'b0, shift_code, 1'b1, '0, 1'b1));
                return;
            end
            if (mode_q == MODE_MULTI && lvl) begin
                if (pulse < threshold_q) begin
                    short_count = short_count + 1'b1;
                    return;
                end
                bits_left = bits_left - 1'b1;
                expected_codes.push_back(make_result(1'b1, '0, 1'b0, short_count,
                                                     bits_left == '0));
                short_count = '0;
                return;
            end
        end

        if (pulse < noise_floor_q)
            return;

        // The short count is deliberately left alone when a frame opens.
        if (lvl && sync_min_q < pulse && pulse < sync_max_q) begin
            shift_code = '0;
            case (mode_q)
                MODE_PW28:   bits_left = BitsPw28;
                MODE_CLKGAP:
                begin
                    bits_left    = BitsClkGap;
                    expect_clock = 1'b0;
                end
                MODE_MULTI:  bits_left = BitsMulti;
                default:     bits_left = BitsPw24;
            endcase
        end
    endfunction

    function automatic void check_field(input string name, input logic [WordW-1:0] exp_val,
                                        input logic [WordW-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_q        = MODE_PW28;
            sync_min_q    = '0;
            sync_max_q    = '0;
            threshold_q   = '0;
            noise_floor_q = NoiseFloorReset;
            shift_code    = '0;
            bits_left     = '0;
            expect_clock  = 1'b0;
            short_count   = '0;
            expected_codes.delete();
            fail_count    = 0;
        end
        else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_MODE:          mode_q = mode_t'(cfg_data[1:0]);
                    REG_SYNC_MIN:      sync_min_q = cfg_data;
                    REG_SYNC_MAX:      sync_max_q = cfg_data;
                    REG_BIT_THRESHOLD: threshold_q = cfg_data;
                    REG_NOISE_FLOOR:   noise_floor_q = cfg_data;
                    default: ;
                endcase
            end

            // Results are compared before this edge's input beat is predicted, so a
            // result can never be matched against the beat that arrives with it.
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual code_word %h count %h",
                             $time, m_tdata[31:0], m_tdata[63:56]);
                    fail_count++;
                end
                else begin
                    want = expected_codes.pop_front();
                    check_field("kind", WordW'(want.kind), WordW'(m_tuser));
                    check_field("code_word", want.code_word, m_tdata[31:0]);
                    check_field("transmitter_id", WordW'(want.transmitter_id),
                                WordW'(m_tdata[47:32]));
                    check_field("command", WordW'(want.command), WordW'(m_tdata[51:48]));
                    check_field("channel", WordW'(want.channel), WordW'(m_tdata[55:52]));
                    check_field("group_count", WordW'(want.group_count),
                                WordW'(m_tdata[63:56]));
                    check_field("last", WordW'(want.last), WordW'(m_tlast));
                end
            end

            if (s_tvalid && s_tready)
                decode_edge(s_tuser, s_tdata);
        end
        codes_outstanding = expected_codes.size();
    end

endmodule

// ===== sim/tb_rf_pulse_code_receiver_core.sv =====
// Testbench top for the RF pulse code receiver core: clock, reset, register writes,
// edge stimulus with random gaps and result back-pressure, and the final verdict.
// Depends on rpcr_pkg, rf_pulse_code_receiver_core and rpcr_code_checker.
module tb_rf_pulse_code_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcr_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [PulseW-1:0]   cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;   // pulse_us
    logic                s_tuser;   // level
    logic                m_tvalid;
    logic                m_tready;
    logic [63:0]         m_tdata;   // code_word, transmitter_id, command, channel,
                                    // group_count
    logic                m_tuser;   // kind
    logic                m_tlast;

    int                  fail_count;
    int                  codes_outstanding;

    // Current stimulus settings, mirrored from the last register writes.
    mode_t               mode_s;
    int                  sync_min_s;
    int                  sync_max_s;
    int                  thr_s;
    int                  edges_sent;
    bit                  tx_burst;
    bit                  rx_burst;
    bit                  wrap_done;

    always #5ns clk = ~clk;

    rf_pulse_code_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rpcr_code_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .fail_count        (fail_count),
        .codes_outstanding (codes_outstanding)
    );

    // Every task below starts and ends at a falling edge. After send_edge returns
    // s_tvalid is still high, so anything other than the next beat drops it first.
    task automatic send_edge(input logic lvl, input logic [23:0] pulse);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pulse;
        s_tuser  <= lvl;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        edges_sent++;
    endtask

    // Waits for every result, then for the edges still in the pipeline to drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (codes_outstanding != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [PulseW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic write_config(input mode_t m, input int smin, input int smax,
                                input int thr, input int noise);
        mode_s     = m;
        sync_min_s = smin;
        sync_max_s = smax;
        thr_s      = thr;
        // Bits above the mode field are junk on purpose.
        write_reg(REG_MODE, PulseW'(($urandom & 32'hFFFFFC) | 32'(m)));
        write_reg(REG_SYNC_MIN, PulseW'(smin));
        write_reg(REG_SYNC_MAX, PulseW'(smax));
        write_reg(REG_BIT_THRESHOLD, PulseW'(thr));
        write_reg(REG_NOISE_FLOOR, PulseW'(noise));
        cfg_we <= 1'b0;
    endtask

    // Pulse length for one bit; now and then exactly on the threshold or at an extreme.
    function automatic logic [23:0] bit_pulse(input bit is_long);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 24'(thr_s);
        if (is_long) begin
            if (r == 1 || thr_s > 24'hFFFFFF - 1000)
                return 24'hFFFFFF;
            return 24'(thr_s + $urandom_range(1, 1000));
        end
        if (r == 1 || thr_s == 0)
            return '0;
        return 24'($urandom_range(0, thr_s - 1));
    endfunction

    function automatic logic [23:0] sync_pulse();
        if (sync_max_s > sync_min_s + 1)
            return 24'($urandom_range(sync_min_s + 1, sync_max_s - 1));
        return 24'($urandom);
    endfunction

    // One sync pulse and a frame body in the current mode, sometimes cut short.
    task automatic send_frame();
        int nbits;
        int stop_at;
        int k;
        nbits   = (mode_s == MODE_PW28) ? 28 : (mode_s == MODE_PW24) ? 24 : 32;
        stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, nbits - 1) : nbits;
        send_edge(1'b1, sync_pulse());
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 31) == 0)
                send_edge(1'($urandom_range(0, 1)), 24'($urandom));
            case (mode_s)
                MODE_PW28, MODE_PW24:
                begin
                    if ($urandom_range(0, 63) == 0)
                        send_edge(1'b1, sync_pulse());
                    send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
                    send_edge(1'b1, 24'($urandom_range(0, sync_min_s)));
                end
                MODE_CLKGAP:
                begin
                    // The sync pulse stands in for the first clock pulse.
                    send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
                    send_edge(1'b1, bit_pulse(1'($urandom_range(0, 1))));
                    if (i < nbits - 1) begin
                        send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
                        send_edge(1'b1, bit_pulse(1'($urandom_range(0, 1))));
                    end
                end
                default:
                begin
                    // One long run of short pulses makes the group count wrap.
                    k = (!wrap_done && i == 3) ? 257 : $urandom_range(0, 3);
                    if (k == 257)
                        wrap_done = 1'b1;
                    repeat (k) begin
                        if (k < 10)
                            send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
                        send_edge(1'b1, thr_s > 0 ? 24'($urandom_range(0, thr_s - 1)) : '0);
                    end
                    send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
                    send_edge(1'b1, bit_pulse(1'b1));
                end
            endcase
        end
    endtask

    // Result side: stalls after some beats and at random moments.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        m_tready <= 1'b1;
        forever begin
            @(posedge clk);
            if ((m_tvalid && m_tready) || $urandom_range(0, 7) == 0) begin
                stall = rx_burst ? 0 : $urandom_range(0, 3);
                if (stall != 0) begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int smin;
        int budget;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings leave the sync window empty, so none of these opens a frame.
        mode_s     = MODE_PW28;
        sync_min_s = 0;
        sync_max_s = 0;
        thr_s      = 0;
        send_edge(1'b1, 24'd0);
        send_edge(1'b0, 24'd0);
        send_edge(1'b1, 24'hFFFFFF);
        send_edge(1'b0, 24'hFFFFFF);
        wait_idle();

        write_config(MODE_MULTI, 1000, 2000, 300, 100);
        send_edge(1'b1, 24'd1000);      // on the lower window bound
        send_edge(1'b1, 24'd2000);      // on the upper window bound
        send_edge(1'b1, 24'd1001);      // opens a frame
        send_edge(1'b1, 24'd0);         // short, counted although below the noise floor
        send_edge(1'b0, 24'd50);
        send_edge(1'b1, 24'd299);
        send_edge(1'b1, 24'd300);       // on the threshold counts as long
        send_edge(1'b1, 24'hFFFFFF);
        send_edge(1'b1, 24'd1500);      // a sync-length pulse is data here
        send_edge(1'b1, 24'd5);         // leaves a count behind
        wait_idle();

        // Switch to a pulse width mode while the frame is still running.
        write_config(MODE_PW24, 1000, 2000, 300, 100);
        send_edge(1'b0, 24'd300);
        send_edge(1'b0, 24'd301);
        send_edge(1'b1, 24'd1999);      // restarts the frame
        send_edge(1'b0, 24'hFFFFFF);
        send_edge(1'b1, 24'd99);

        edges_sent = 0;
        for (int p = 0; edges_sent < 900 || p < 8; p++) begin
            wait_idle();
            case (p)
                4: write_config(MODE_PW28, 0, 24'hFFFFFF, 0, 0);
                5: write_config(MODE_CLKGAP, 1000, 2000, 24'hFFFFFF, 24'hFFFFFF);
                6: write_config(MODE_MULTI, 10, 11, 300, 100);
                default:
                begin
                    smin = $urandom_range(1000, 4000);
                    write_config(p < 8 ? mode_t'(p % 4) : mode_t'($urandom_range(0, 3)),
                                 smin, smin + $urandom_range(2, 3000),
                                 $urandom_range(200, 800), $urandom_range(0, 150));
                end
            endcase
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            budget   = edges_sent + ((p == 5) ? 30 : $urandom_range(30, 90));
            while (edges_sent < budget) begin
                if ($urandom_range(0, 9) == 0)
                    repeat (5) send_edge(1'($urandom_range(0, 1)), 24'($urandom));
                else
                    send_frame();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
